/* sv/sfdp_pkg.sv */
// Shared types and constants for the shading frame / diffuse density pipeline.
// No dependencies; imported by sfdp_unitize and shading_frame_diffuse_pdf_top.
`timescale 1ns / 1ps
`default_nettype none

package sfdp_pkg;

    // 1/pi as an unsigned Q32 fraction (fits in 31 bits).
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

    // Control that travels with the result of a normalizer.
    typedef struct packed {
        logic valid;
        logic zero;
    } t_sfdp_ctl;

endpackage

`default_nettype wire

/* sv/sfdp_unitize.sv */
// Pipelined vector normalizer: squares, sum, bit-serial square root, restoring divide.
// Depends on sfdp_pkg; instantiated twice by shading_frame_diffuse_pdf_top.
`timescale 1ns / 1ps
`default_nettype none

module sfdp_unitize import sfdp_pkg::*; #(
    parameter int W   = 16,
    parameter int SBW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2:0][W-1:0]   i_vec,
    input  logic [SBW-1:0]      i_sb,
    output t_sfdp_ctl           o_ctl,
    output logic [2:0][W-1:0]   o_vec,
    output logic [SBW-1:0]      o_sb
);

    localparam int F  = W - 2;
    localparam int SW = 2 * W;
    localparam int NW = 2 * W - 1;
    localparam int QW = F + 1;

    // Input register.
    logic                r_a_vld;
    logic [2:0][W-1:0]   r_a_vec;
    logic [SBW-1:0]      r_a_sb;

    // Squares.
    logic                r_b_vld;
    logic [2:0][SW-1:0]  r_b_sq;
    logic [2:0][W-1:0]   r_b_vec;
    logic [SBW-1:0]      r_b_sb;
    logic signed [SW-1:0] a_sq [3];

    // Square root stages; index 0 holds the sum of squares.
    logic                r_s_vld  [0:W];
    logic [SW-1:0]       r_s_rem  [0:W];
    logic [SW-1:0]       r_s_res  [0:W];
    logic                r_s_zero [0:W];
    logic [2:0][W-1:0]   r_s_vec  [0:W];
    logic [SBW-1:0]      r_s_sb   [0:W];

    // Divide stages; index 0 holds the rounded numerators.
    logic                r_d_vld  [0:QW];
    logic [2:0][NW-1:0]  r_d_rem  [0:QW];
    logic [2:0][QW-1:0]  r_d_q    [0:QW];
    logic [2:0]          r_d_sg   [0:QW];
    logic [W-1:0]        r_d_den  [0:QW];
    logic                r_d_zero [0:QW];
    logic [SBW-1:0]      r_d_sb   [0:QW];

    // Result register.
    logic                r_e_vld;
    logic                r_e_zero;
    logic [2:0][W-1:0]   r_e_vec;
    logic [SBW-1:0]      r_e_sb;

    logic [2:0][NW-1:0]  n_d_num;
    logic [2:0][W-1:0]   n_e_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_s_vld[0] <= 1'b0;
            r_d_vld[0] <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_s_vld[0] <= r_b_vld;
            r_d_vld[0] <= r_s_vld[W];
            r_e_vld <= r_d_vld[QW];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            a_sq[c] = $signed(r_a_vec[c]) * $signed(r_a_vec[c]);
        end
    end

    // Numerator = |v| * 2^F + len / 2, so the quotient rounds to nearest.
    always_comb begin
        logic [W-1:0] len;
        logic [W-1:0] mag;
        len = r_s_res[W][W-1:0];
        for (int c = 0; c < 3; c++) begin
            mag = r_s_vec[W][c][W-1] ? (W'(0) - r_s_vec[W][c]) : r_s_vec[W][c];
            n_d_num[c] = (NW'(mag) << F) + NW'(len >> 1);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_e_vec[c] = r_d_sg[QW][c] ? (W'(0) - W'(r_d_q[QW][c])) : W'(r_d_q[QW][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_vec <= i_vec;
            r_a_sb  <= i_sb;
            for (int c = 0; c < 3; c++) begin
                r_b_sq[c] <= unsigned'(a_sq[c]);
            end
            r_b_vec <= r_a_vec;
            r_b_sb  <= r_a_sb;
            r_s_rem[0]  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_s_res[0]  <= '0;
            r_s_zero[0] <= (r_b_sq[0] + r_b_sq[1] + r_b_sq[2]) == '0;
            r_s_vec[0]  <= r_b_vec;
            r_s_sb[0]   <= r_b_sb;
            r_d_rem[0]  <= n_d_num;
            r_d_q[0]    <= '0;
            for (int c = 0; c < 3; c++) begin
                r_d_sg[0][c] <= r_s_vec[W][c][W-1];
            end
            r_d_den[0]  <= r_s_res[W][W-1:0];
            r_d_zero[0] <= r_s_zero[W];
            r_d_sb[0]   <= r_s_sb[W];
            r_e_vec  <= n_e_vec;
            r_e_zero <= r_d_zero[QW];
            r_e_sb   <= r_d_sb[QW];
        end
    end

    // One result bit of the square root per stage.
    for (genvar k = 0; k < W; k++) begin : g_sqrt
        logic [SW-1:0] g_bit;
        logic [SW-1:0] g_try;
        assign g_bit = SW'(1) << (2 * (W - 1 - k));
        assign g_try = r_s_res[k] + g_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_s_vld[k+1] <= r_s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_s_rem[k] >= g_try) begin
                    r_s_rem[k+1] <= r_s_rem[k] - g_try;
                    r_s_res[k+1] <= (r_s_res[k] >> 1) + g_bit;
                end else begin
                    r_s_rem[k+1] <= r_s_rem[k];
                    r_s_res[k+1] <= r_s_res[k] >> 1;
                end
                r_s_zero[k+1] <= r_s_zero[k];
                r_s_vec[k+1]  <= r_s_vec[k];
                r_s_sb[k+1]   <= r_s_sb[k];
            end
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [NW-1:0]      g_dsh;
        logic [2:0][NW-1:0] g_rem;
        logic [2:0][QW-1:0] g_q;
        assign g_dsh = NW'(r_d_den[k]) << (F - k);

        always_comb begin
            g_rem = r_d_rem[k];
            g_q   = r_d_q[k];
            for (int c = 0; c < 3; c++) begin
                if (r_d_rem[k][c] >= g_dsh) begin
                    g_rem[c] = r_d_rem[k][c] - g_dsh;
                    g_q[c][F-k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_d_vld[k+1] <= r_d_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d_rem[k+1]  <= g_rem;
                r_d_q[k+1]    <= g_q;
                r_d_sg[k+1]   <= r_d_sg[k];
                r_d_den[k+1]  <= r_d_den[k];
                r_d_zero[k+1] <= r_d_zero[k];
                r_d_sb[k+1]   <= r_d_sb[k];
            end
        end
    end

    assign o_ctl.valid = r_e_vld;
    assign o_ctl.zero  = r_e_zero;
    assign o_vec       = r_e_vec;
    assign o_sb        = r_e_sb;

    // Integer square root leaves a remainder of at most twice the root.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_vld[W] |-> ({1'b0, r_s_rem[W]} <= {r_s_res[W], 1'b0}))
        else $error("square root remainder out of range");

    // A nonzero vector never reaches the divider with a zero length.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[0] && !r_d_zero[0] |-> r_d_den[0] != '0)
        else $error("zero divisor for nonzero vector");

    // Unit components never exceed one.
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[QW] && !r_d_zero[QW] |->
            r_d_q[QW][0] <= (QW'(1) << F) && r_d_q[QW][1] <= (QW'(1) << F) &&
            r_d_q[QW][2] <= (QW'(1) << F))
        else $error("unit component above one");

endmodule

`default_nettype wire

/* sv/shading_frame_diffuse_pdf_top.sv */
// Top level of the shading frame / diffuse density pipeline.
// Depends on sfdp_pkg and sfdp_unitize.
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries a surface normal and two world directions, wo and
// wi, as signed fixed-point components with COMPONENT_BITS-2 fraction bits.
// The block normalizes the normal, builds a perpendicular binormal (chosen
// by comparing |n.x| with |n.z|), normalizes it, forms tangent = binormal x
// normal, and returns wi in that frame, wo projected on the normal and the
// cosine density |wi.n|/pi as an unsigned Q0.COMPONENT_BITS fraction, which
// is zero unless wo and wi lie strictly on the same side. All outputs round
// to nearest and saturate. A zero normal or binormal sets the degenerate flag
// in tuser and zeroes every numeric field. The pipeline accepts one item per
// clock unless the output is stalled; on its way to the output register each
// item passes through the two normalizers, each of which spends one stage per
// square-root bit and one stage per quotient bit. The whole pipeline advances
// whenever the output register is empty or being taken, so a stalled output
// holds every item in place and nothing is lost.
module shading_frame_diffuse_pdf_top import sfdp_pkg::*; #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // normal_x, normal_y, normal_z, out_dir_x, out_dir_y, out_dir_z,
    // in_dir_x, in_dir_y, in_dir_z (lowest bits first), zero padded.
    input  logic [((9*COMPONENT_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // local_in_tangent, local_in_binormal, local_in_normal, local_out_normal,
    // diffuse_density (lowest bits first), zero padded.
    output logic [((5*COMPONENT_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // degenerate_frame.
    output logic [0:0]                             m_axis_tuser
);

    localparam int W    = COMPONENT_BITS;
    localparam int F    = W - 2;
    localparam int PW   = 2 * W + 2;
    localparam int DW   = W + 31;
    localparam int OTW  = ((5 * W + 7) / 8) * 8;
    localparam int SB1  = 6 * W;
    localparam int SB2  = 9 * W + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
    localparam logic [PW-1:0] MAXP = (PW'(1) << (W - 1)) - PW'(1);
    localparam logic [PW-1:0] MAXN = PW'(1) << (W - 1);
    localparam logic [DW:0]   DHALF = (DW+1)'(1) << 29;
    localparam logic [DW:0]   DMAX  = ((DW+1)'(1) << W) - (DW+1)'(1);

    // Round a wide product sum by 2^F, halves away from zero, and saturate.
    function automatic logic [W-1:0] f_rescale(input logic [PW-1:0] v);
        logic          neg;
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        neg = v[PW-1];
        mag = neg ? (PW'(0) - v) : v;
        q   = (mag + HALF) >> F;
        if (!neg) begin
            return (q > MAXP) ? {1'b0, {(W-1){1'b1}}} : W'(q);
        end else begin
            return (q > MAXN) ? {1'b1, {(W-1){1'b0}}} : W'(PW'(0) - q);
        end
    endfunction

    logic en;

    // Output register.
    logic                r_o_vld;
    logic [3:0][W-1:0]   r_o_loc;
    logic [W-1:0]        r_o_dens;
    logic                r_o_deg;

    // Both normalizers advance with the rest of the pipeline.
    assign en            = !r_o_vld || m_axis_tready;
    assign s_axis_tready = en;

    // First normalizer: the surface normal; the directions ride alongside.
    t_sfdp_ctl           u1_ctl;
    logic [2:0][W-1:0]   u1_vec;
    logic [SB1-1:0]      u1_sb;

    sfdp_unitize #(.W(W), .SBW(SB1)) u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_vec   (s_axis_tdata[3*W-1:0]),
        .i_sb    (s_axis_tdata[9*W-1:3*W]),
        .o_ctl   (u1_ctl),
        .o_vec   (u1_vec),
        .o_sb    (u1_sb)
    );

    // Binormal choice: (-n.y, n.x, 0) when |n.x| > |n.z|, else (0, -n.z, n.y).
    logic [2:0][W-1:0]   bsel;
    always_comb begin
        logic [W-1:0] mx;
        logic [W-1:0] mz;
        mx = u1_vec[0][W-1] ? (W'(0) - u1_vec[0]) : u1_vec[0];
        mz = u1_vec[2][W-1] ? (W'(0) - u1_vec[2]) : u1_vec[2];
        if (mx > mz) begin
            bsel[0] = W'(0) - u1_vec[1];
            bsel[1] = u1_vec[0];
            bsel[2] = '0;
        end else begin
            bsel[0] = '0;
            bsel[1] = W'(0) - u1_vec[2];
            bsel[2] = u1_vec[1];
        end
    end

    // Second normalizer: the binormal; carries zero flag, unit normal, wi, wo.
    t_sfdp_ctl           u2_ctl;
    logic [2:0][W-1:0]   u2_vec;
    logic [SB2-1:0]      u2_sb;

    sfdp_unitize #(.W(W), .SBW(SB2)) u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (u1_ctl.valid),
        .i_vec   (bsel),
        .i_sb    ({u1_ctl.zero, u1_vec, u1_sb}),
        .o_ctl   (u2_ctl),
        .o_vec   (u2_vec),
        .o_sb    (u2_sb)
    );

    logic [2:0][W-1:0] u2_n;
    logic [2:0][W-1:0] u2_wi;
    logic [2:0][W-1:0] u2_wo;
    assign u2_wo = u2_sb[3*W-1:0];
    assign u2_wi = u2_sb[6*W-1:3*W];
    assign u2_n  = u2_sb[9*W-1:6*W];

    // Stage 3: cross product terms.
    logic                 r3_vld;
    logic                 r3_deg;
    logic [5:0][2*W-1:0]  r3_pr;
    logic [2:0][W-1:0]    r3_b, r3_n, r3_wi, r3_wo;
    // Stage 4: tangent.
    logic                 r4_vld;
    logic                 r4_deg;
    logic [2:0][W-1:0]    r4_t, r4_b, r4_n, r4_wi, r4_wo;
    // Stage 5: dot product terms, three per projection.
    logic                 r5_vld;
    logic                 r5_deg;
    logic [11:0][2*W-1:0] r5_pr;
    // Stage 6: dot product sums.
    logic                 r6_vld;
    logic                 r6_deg;
    logic [3:0][PW-1:0]   r6_sum;
    // Stage 7: rounded projections.
    logic                 r7_vld;
    logic                 r7_deg;
    logic [3:0][W-1:0]    r7_loc;
    // Stage 8: density product.
    logic                 r8_vld;
    logic                 r8_deg;
    logic                 r8_same;
    logic [DW-1:0]        r8_p;
    logic [3:0][W-1:0]    r8_loc;

    logic [5:0][2*W-1:0]  n3_pr;
    logic [11:0][2*W-1:0] n5_pr;
    logic [3:0][PW-1:0]   n6_sum;
    logic [W-1:0]         n8_mag;
    logic                 n8_same;
    logic [DW:0]          n9_d;
    logic [W-1:0]         n9_dens;

    always_comb begin
        n3_pr[0] = $signed(u2_vec[1]) * $signed(u2_n[2]);
        n3_pr[1] = $signed(u2_vec[2]) * $signed(u2_n[1]);
        n3_pr[2] = $signed(u2_vec[2]) * $signed(u2_n[0]);
        n3_pr[3] = $signed(u2_vec[0]) * $signed(u2_n[2]);
        n3_pr[4] = $signed(u2_vec[0]) * $signed(u2_n[1]);
        n3_pr[5] = $signed(u2_vec[1]) * $signed(u2_n[0]);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n5_pr[c]     = $signed(r4_wi[c]) * $signed(r4_t[c]);
            n5_pr[3 + c] = $signed(r4_wi[c]) * $signed(r4_b[c]);
            n5_pr[6 + c] = $signed(r4_wi[c]) * $signed(r4_n[c]);
            n5_pr[9 + c] = $signed(r4_wo[c]) * $signed(r4_n[c]);
        end
        for (int k = 0; k < 4; k++) begin
            n6_sum[k] = PW'($signed(r5_pr[3*k])) + PW'($signed(r5_pr[3*k + 1]))
                      + PW'($signed(r5_pr[3*k + 2]));
        end
    end

    // Density uses |wi.n| scaled by 4/pi; same side means a positive product.
    always_comb begin
        n8_mag  = r7_loc[2][W-1] ? (W'(0) - r7_loc[2]) : r7_loc[2];
        n8_same = (r7_loc[2] != '0) && (r7_loc[3] != '0)
                  && (r7_loc[2][W-1] == r7_loc[3][W-1]);
        n9_d    = ((DW+1)'(r8_p) + DHALF) >> 30;
        if (!r8_same) begin
            n9_dens = '0;
        end else if (n9_d > DMAX) begin
            n9_dens = '1;
        end else begin
            n9_dens = W'(n9_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r3_vld  <= u2_ctl.valid;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r_o_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_deg <= u2_ctl.zero | u2_sb[9*W];
            r3_pr  <= n3_pr;
            r3_b   <= u2_vec;
            r3_n   <= u2_n;
            r3_wi  <= u2_wi;
            r3_wo  <= u2_wo;

            r4_deg  <= r3_deg;
            r4_t[0] <= f_rescale(PW'($signed(r3_pr[0])) - PW'($signed(r3_pr[1])));
            r4_t[1] <= f_rescale(PW'($signed(r3_pr[2])) - PW'($signed(r3_pr[3])));
            r4_t[2] <= f_rescale(PW'($signed(r3_pr[4])) - PW'($signed(r3_pr[5])));
            r4_b    <= r3_b;
            r4_n    <= r3_n;
            r4_wi   <= r3_wi;
            r4_wo   <= r3_wo;

            r5_deg <= r4_deg;
            r5_pr  <= n5_pr;

            r6_deg <= r5_deg;
            r6_sum <= n6_sum;

            r7_deg <= r6_deg;
            for (int k = 0; k < 4; k++) begin
                r7_loc[k] <= f_rescale(r6_sum[k]);
            end

            r8_deg  <= r7_deg;
            r8_same <= n8_same;
            r8_p    <= DW'(n8_mag) * DW'(INV_PI_Q32);
            r8_loc  <= r7_loc;

            r_o_deg  <= r8_deg;
            r_o_loc  <= r8_deg ? '0 : r8_loc;
            r_o_dens <= r8_deg ? '0 : n9_dens;
        end
    end

    assign m_axis_tvalid   = r_o_vld;
    assign m_axis_tdata    = OTW'({r_o_dens, r_o_loc});
    assign m_axis_tuser[0] = r_o_deg;

    // A degenerate frame carries only zeros.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_deg |-> r_o_loc == '0 && r_o_dens == '0)
        else $error("degenerate item with nonzero fields");

    // A nonzero density needs wo and wi strictly on the same side.
    a_dens_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_dens != '0 |->
            r_o_loc[2] != '0 && r_o_loc[3] != '0 && r_o_loc[2][W-1] == r_o_loc[3][W-1])
        else $error("density on opposite sides");

    // A held result blocks new items.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule

`default_nettype wire
